FILE: rtl/mhsi_pkg.sv
`default_nettype none
package mhsi_pkg;

	localparam int FRAC_BITS = 14;

	localparam int AXIS_W  = 16;
	localparam int DIFF_W  = AXIS_W + 1;
	localparam int PROD_W  = AXIS_W + DIFF_W;
	localparam int SUM_W   = PROD_W + 2;
	localparam int SQ_W    = 2 * AXIS_W;
	localparam int ROW_W   = 3 * AXIS_W;
	localparam int BOUND_W = 32;
	localparam int CFG_W   = ROW_W;
	localparam int IDX_W   = 3;

	localparam logic [IDX_W-1:0] REG_HARD_IRON_X    = 3'd0;
	localparam logic [IDX_W-1:0] REG_HARD_IRON_Y    = 3'd1;
	localparam logic [IDX_W-1:0] REG_HARD_IRON_Z    = 3'd2;
	localparam logic [IDX_W-1:0] REG_SOFT_IRON_ROW0 = 3'd3;
	localparam logic [IDX_W-1:0] REG_SOFT_IRON_ROW1 = 3'd4;
	localparam logic [IDX_W-1:0] REG_SOFT_IRON_ROW2 = 3'd5;
	localparam logic [IDX_W-1:0] REG_MIN_FIELD_SQ   = 3'd6;
	localparam logic [IDX_W-1:0] REG_MAX_FIELD_SQ   = 3'd7;

	localparam logic [AXIS_W-1:0] COEF_ONE = AXIS_W'(1 << FRAC_BITS);
	localparam logic [ROW_W-1:0] ROW0_RST = {COEF_ONE, {AXIS_W{1'b0}}, {AXIS_W{1'b0}}};
	localparam logic [ROW_W-1:0] ROW1_RST = {{AXIS_W{1'b0}}, COEF_ONE, {AXIS_W{1'b0}}};
	localparam logic [ROW_W-1:0] ROW2_RST = {{AXIS_W{1'b0}}, {AXIS_W{1'b0}}, COEF_ONE};

	// Number of register stages from an accepted transaction to its result.
	localparam int LATENCY = 5;

	typedef struct packed {
		logic signed [AXIS_W-1:0] raw_x;
		logic signed [AXIS_W-1:0] raw_y;
		logic signed [AXIS_W-1:0] raw_z;
	} in_t;

	typedef struct packed {
		logic signed [AXIS_W-1:0] cal_x;
		logic signed [AXIS_W-1:0] cal_y;
		logic signed [AXIS_W-1:0] cal_z;
		logic                     disturbed;
	} out_t;

	typedef struct packed {
		logic signed [DIFF_W-1:0] dx;
		logic signed [DIFF_W-1:0] dy;
		logic signed [DIFF_W-1:0] dz;
	} diff_t;

	typedef struct packed {
		logic signed [AXIS_W-1:0] cal;
		logic [SQ_W-1:0]          sq;
	} lane_res_t;

endpackage
`default_nettype wire

FILE: rtl/mhsi_lane.sv
`default_nettype none
module mhsi_lane (
	input  wire logic              clk,
	input  wire logic [47:0]       row,
	input  wire mhsi_pkg::diff_t   d_s1,
	output mhsi_pkg::lane_res_t    res_s4
);
	import mhsi_pkg::*;

	localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(32767);
	localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-32768);

	logic signed [AXIS_W-1:0] cx;
	logic signed [AXIS_W-1:0] cy;
	logic signed [AXIS_W-1:0] cz;
	logic signed [PROD_W-1:0] px_s2;
	logic signed [PROD_W-1:0] py_s2;
	logic signed [PROD_W-1:0] pz_s2;
	logic signed [SUM_W-1:0]  sum;
	logic signed [SUM_W-1:0]  shifted;
	logic signed [AXIS_W-1:0] sat;
	logic signed [AXIS_W-1:0] cal_s3;

	assign cx = row[3*AXIS_W-1:2*AXIS_W];
	assign cy = row[2*AXIS_W-1:AXIS_W];
	assign cz = row[AXIS_W-1:0];

	always_ff @(posedge clk) begin
		px_s2 <= cx * d_s1.dx;
		py_s2 <= cy * d_s1.dy;
		pz_s2 <= cz * d_s1.dz;
	end

	// The arithmetic shift rounds toward minus infinity before clamping.
	always_comb begin
		sum     = SUM_W'(px_s2) + SUM_W'(py_s2) + SUM_W'(pz_s2);
		shifted = sum >>> FRAC_BITS;
		if (shifted > SAT_HI) begin
			sat = AXIS_W'(SAT_HI);
		end else if (shifted < SAT_LO) begin
			sat = AXIS_W'(SAT_LO);
		end else begin
			sat = shifted[AXIS_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		cal_s3     <= sat;
		res_s4.cal <= cal_s3;
		res_s4.sq  <= SQ_W'(cal_s3 * cal_s3);
	end

endmodule
`default_nettype wire

FILE: rtl/mhsi_merge.sv
`default_nettype none
module mhsi_merge (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                v_s4,
	input  wire mhsi_pkg::lane_res_t lane_x_s4,
	input  wire mhsi_pkg::lane_res_t lane_y_s4,
	input  wire mhsi_pkg::lane_res_t lane_z_s4,
	input  wire logic [31:0]         min_field_sq,
	input  wire logic [31:0]         max_field_sq,
	output logic                     done,
	output mhsi_pkg::out_t           result
);
	import mhsi_pkg::*;

	// Three squares of 16-bit values sum to at most 3 * 2^30, so 32 bits suffice.
	logic [SQ_W-1:0] mag_sq;

	assign mag_sq = lane_x_s4.sq + lane_y_s4.sq + lane_z_s4.sq;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		result.cal_x     <= lane_x_s4.cal;
		result.cal_y     <= lane_y_s4.cal;
		result.cal_z     <= lane_z_s4.cal;
		result.disturbed <= (mag_sq < min_field_sq) || (mag_sq > max_field_sq);
	end

endmodule
`default_nettype wire

FILE: rtl/mag_hard_soft_iron_correct_unit.sv
`default_nettype none
// Magnetometer hard-iron and soft-iron correction.
//
// Input: a transaction is taken at each rising edge with start high and busy
// low; sample carries raw_x, raw_y and raw_z. busy is always low, so a new
// sample may be presented in every cycle.
// Output: done is high for exactly one cycle with the corrected axes and the
// disturbance flag on result. The receiver has no way to stall; every result
// must be taken in the cycle it is shown.
// Throughput is one sample per cycle. Each sample passes through the pipeline
// registers in order: offset subtract, one multiplier per coefficient in each
// row lane, row sum with shift and saturation, squaring, then the magnitude
// compare.
// Configuration: cfg_wr writes cfg_data into register cfg_idx at the clock
// edge; write only while no sample is in flight.
// Reset: arst_n clears the pipeline valids and loads zero offsets, the
// identity matrix and the widest magnitude bounds.
module mag_hard_soft_iron_correct_unit (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire mhsi_pkg::in_t                  sample,
	input  wire logic                           cfg_wr,
	input  wire logic [mhsi_pkg::IDX_W-1:0]     cfg_idx,
	input  wire logic [mhsi_pkg::CFG_W-1:0]     cfg_data,
	output logic                                done,
	output mhsi_pkg::out_t                      result
);
	import mhsi_pkg::*;

	logic signed [AXIS_W-1:0] hard_iron_x_q;
	logic signed [AXIS_W-1:0] hard_iron_y_q;
	logic signed [AXIS_W-1:0] hard_iron_z_q;
	logic [ROW_W-1:0]         row0_q;
	logic [ROW_W-1:0]         row1_q;
	logic [ROW_W-1:0]         row2_q;
	logic [BOUND_W-1:0]       min_sq_q;
	logic [BOUND_W-1:0]       max_sq_q;

	logic      accept;
	logic      v_s1;
	logic      v_s2;
	logic      v_s3;
	logic      v_s4;
	diff_t     d_s1;
	lane_res_t lane_x_s4;
	lane_res_t lane_y_s4;
	lane_res_t lane_z_s4;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hard_iron_x_q <= '0;
			hard_iron_y_q <= '0;
			hard_iron_z_q <= '0;
			row0_q        <= ROW0_RST;
			row1_q        <= ROW1_RST;
			row2_q        <= ROW2_RST;
			min_sq_q      <= '0;
			max_sq_q      <= '1;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_HARD_IRON_X:    hard_iron_x_q <= cfg_data[AXIS_W-1:0];
				REG_HARD_IRON_Y:    hard_iron_y_q <= cfg_data[AXIS_W-1:0];
				REG_HARD_IRON_Z:    hard_iron_z_q <= cfg_data[AXIS_W-1:0];
				REG_SOFT_IRON_ROW0: row0_q        <= cfg_data[ROW_W-1:0];
				REG_SOFT_IRON_ROW1: row1_q        <= cfg_data[ROW_W-1:0];
				REG_SOFT_IRON_ROW2: row2_q        <= cfg_data[ROW_W-1:0];
				REG_MIN_FIELD_SQ:   min_sq_q      <= cfg_data[BOUND_W-1:0];
				REG_MAX_FIELD_SQ:   max_sq_q      <= cfg_data[BOUND_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// The 17-bit differences are exact for any sample and offset.
	always_ff @(posedge clk) begin
		d_s1.dx <= DIFF_W'(sample.raw_x) - DIFF_W'(hard_iron_x_q);
		d_s1.dy <= DIFF_W'(sample.raw_y) - DIFF_W'(hard_iron_y_q);
		d_s1.dz <= DIFF_W'(sample.raw_z) - DIFF_W'(hard_iron_z_q);
	end

	mhsi_lane u_lane_x (
		.clk    (clk),
		.row    (row0_q),
		.d_s1   (d_s1),
		.res_s4 (lane_x_s4)
	);

	mhsi_lane u_lane_y (
		.clk    (clk),
		.row    (row1_q),
		.d_s1   (d_s1),
		.res_s4 (lane_y_s4)
	);

	mhsi_lane u_lane_z (
		.clk    (clk),
		.row    (row2_q),
		.d_s1   (d_s1),
		.res_s4 (lane_z_s4)
	);

	mhsi_merge u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.v_s4         (v_s4),
		.lane_x_s4    (lane_x_s4),
		.lane_y_s4    (lane_y_s4),
		.lane_z_s4    (lane_z_s4),
		.min_field_sq (min_sq_q),
		.max_field_sq (max_sq_q),
		.done         (done),
		.result       (result)
	);

endmodule
`default_nettype wire

FILE: rtl/mhsi_checker.sv
`default_nettype none
module mhsi_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           start,
	input wire logic           busy,
	input wire logic           done,
	input wire mhsi_pkg::out_t result
);
	import mhsi_pkg::*;

	// The pipeline never pushes back on the sender.
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy asserted");

	// Every accepted transaction produces a result after the pipeline latency.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("accepted transaction produced no result");

	// No result appears without a transaction accepted the latency earlier.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without an accepted transaction");

	// A shown result never carries unknown bits.
	a_result_known: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !$isunknown(result))
		else $error("result carries unknown bits");

endmodule

bind mag_hard_soft_iron_correct_unit mhsi_checker u_mhsi_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);
`default_nettype wire

FILE: test/mag_hard_soft_iron_correct_unit_tb.sv
module mag_hard_soft_iron_correct_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mhsi_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int NUM_PHASES = 10;
	localparam int PHASE_ITEMS = 75;

	typedef logic [CFG_W-1:0] reg_file_t [8];

	typedef struct {
		int   cfg;
		in_t  smp;
		bit   known;
		out_t want;
	} dir_row_t;

	logic            clk;
	logic            arst_n;
	logic            start;
	logic            busy;
	in_t             sample;
	logic            cfg_wr;
	logic [IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0] cfg_data;
	logic            done;
	out_t            result;

	reg_file_t cal_regs;
	out_t      pending_cal [$];
	int        errors = 0;
	int        idle_cycles = 0;
	bit        steady = 0;
	int        rad_bits = 8;

	// Register sets for the directed rows: reset values, full-scale matrix with
	// extreme offsets, inverted bounds, equal bounds, and fractional coefficients.
	reg_file_t dir_cfg [5] = '{
		'{48'h0, 48'h0, 48'h0, ROW0_RST, ROW1_RST, ROW2_RST, 48'h0, 48'hFFFF_FFFF},
		'{48'h8000, 48'h7FFF, 48'h0, 48'h7FFF_7FFF_7FFF, 48'h8000_8000_8000,
			48'h7FFF_8000_0000, 48'h0, 48'hFFFF_FFFF},
		'{48'h0, 48'h0, 48'h0, ROW0_RST, ROW1_RST, ROW2_RST, 48'h1, 48'h0},
		'{48'h0, 48'h0, 48'h0, ROW0_RST, ROW1_RST, ROW2_RST, 48'hC000_0000, 48'hC000_0000},
		'{48'h0001, 48'hFFFF, 48'h7FFF, 48'h2000_0000_0000, 48'h0000_E000_0000,
			48'h0001_0001_FFFF, 48'h1000_0000, 48'h3000_0000}
	};

	dir_row_t dir_tab [22] = '{
		'{0, {16'h0000, 16'h0000, 16'h0000}, 1, {16'h0000, 16'h0000, 16'h0000, 1'b0}},
		'{0, {16'h7FFF, 16'h7FFF, 16'h7FFF}, 1, {16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0}},
		'{0, {16'h8000, 16'h8000, 16'h8000}, 1, {16'h8000, 16'h8000, 16'h8000, 1'b0}},
		'{0, {16'h7FFF, 16'h8000, 16'h0001}, 1, {16'h7FFF, 16'h8000, 16'h0001, 1'b0}},
		'{0, {16'hFFFF, 16'h0001, 16'h5555}, 1, {16'hFFFF, 16'h0001, 16'h5555, 1'b0}},
		'{0, {16'hAAAA, 16'h5555, 16'h8001}, 1, {16'hAAAA, 16'h5555, 16'h8001, 1'b0}},
		'{1, {16'h7FFF, 16'h7FFF, 16'h7FFF}, 0, 49'h0},
		'{1, {16'h8000, 16'h8000, 16'h8000}, 0, 49'h0},
		'{1, {16'h0000, 16'h0000, 16'h0000}, 0, 49'h0},
		'{1, {16'h7FFF, 16'h8000, 16'h7FFF}, 0, 49'h0},
		'{1, {16'h8000, 16'h7FFF, 16'h8000}, 0, 49'h0},
		'{1, {16'h1234, 16'hFEDC, 16'h0F0F}, 0, 49'h0},
		'{2, {16'h0000, 16'h0000, 16'h0000}, 1, {16'h0000, 16'h0000, 16'h0000, 1'b1}},
		'{2, {16'h7FFF, 16'h7FFF, 16'h7FFF}, 1, {16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1}},
		'{2, {16'h0001, 16'h0000, 16'h0000}, 1, {16'h0001, 16'h0000, 16'h0000, 1'b1}},
		'{3, {16'h8000, 16'h8000, 16'h8000}, 1, {16'h8000, 16'h8000, 16'h8000, 1'b0}},
		'{3, {16'h7FFF, 16'h7FFF, 16'h7FFF}, 1, {16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1}},
		'{3, {16'h0000, 16'h0000, 16'h0000}, 1, {16'h0000, 16'h0000, 16'h0000, 1'b1}},
		'{4, {16'h0002, 16'h0000, 16'h0000}, 0, 49'h0},
		'{4, {16'h0000, 16'hFFFE, 16'h8000}, 0, 49'h0},
		'{4, {16'h8000, 16'h7FFF, 16'h7FFF}, 0, 49'h0},
		'{4, {16'h1357, 16'h2468, 16'hFFFF}, 0, 49'h0}
	};

	mag_hard_soft_iron_correct_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.sample(sample),
		.cfg_wr(cfg_wr),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.done(done),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// One matrix row applied to the offset-corrected vector, floored and clamped.
	function automatic logic signed [AXIS_W-1:0] apply_row(logic [ROW_W-1:0] row,
			longint dx, longint dy, longint dz);
		longint acc;
		acc = longint'($signed(row[47:32])) * dx + longint'($signed(row[31:16])) * dy
			+ longint'($signed(row[15:0])) * dz;
		acc = acc >>> FRAC_BITS;
		if (acc > 32767)
			acc = 32767;
		else if (acc < -32768)
			acc = -32768;
		return AXIS_W'(acc);
	endfunction

	function automatic out_t correct_sample(in_t s);
		longint dx, dy, dz, mag_sq;
		out_t r;
		dx = longint'($signed(s.raw_x)) - longint'($signed(cal_regs[REG_HARD_IRON_X][15:0]));
		dy = longint'($signed(s.raw_y)) - longint'($signed(cal_regs[REG_HARD_IRON_Y][15:0]));
		dz = longint'($signed(s.raw_z)) - longint'($signed(cal_regs[REG_HARD_IRON_Z][15:0]));
		r.cal_x = apply_row(cal_regs[REG_SOFT_IRON_ROW0], dx, dy, dz);
		r.cal_y = apply_row(cal_regs[REG_SOFT_IRON_ROW1], dx, dy, dz);
		r.cal_z = apply_row(cal_regs[REG_SOFT_IRON_ROW2], dx, dy, dz);
		mag_sq = longint'($signed(r.cal_x)) * longint'($signed(r.cal_x))
			+ longint'($signed(r.cal_y)) * longint'($signed(r.cal_y))
			+ longint'($signed(r.cal_z)) * longint'($signed(r.cal_z));
		r.disturbed = (mag_sq < longint'(cal_regs[REG_MIN_FIELD_SQ][31:0]))
			|| (mag_sq > longint'(cal_regs[REG_MAX_FIELD_SQ][31:0]));
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	function automatic logic [AXIS_W-1:0] pick_extreme();
		case ($urandom_range(0, 4))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return 16'h0001;
		endcase
	endfunction

	function automatic logic [AXIS_W-1:0] near_offset(logic [CFG_W-1:0] off);
		int span;
		span = 1 << rad_bits;
		return off[15:0] + AXIS_W'(int'($urandom_range(0, 2 * span)) - span);
	endfunction

	function automatic in_t rand_sample();
		int r;
		in_t s;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			s.raw_x = near_offset(cal_regs[REG_HARD_IRON_X]);
			s.raw_y = near_offset(cal_regs[REG_HARD_IRON_Y]);
			s.raw_z = near_offset(cal_regs[REG_HARD_IRON_Z]);
		end else if (r < 85) begin
			s = 48'({$urandom(), $urandom()});
		end else begin
			s.raw_x = pick_extreme();
			s.raw_y = pick_extreme();
			s.raw_z = pick_extreme();
		end
		return s;
	endfunction

	function automatic logic [AXIS_W-1:0] rand_coef(bit diag);
		if ($urandom_range(0, 9) < 6)
			return (diag ? COEF_ONE : 16'h0000) + AXIS_W'(int'($urandom_range(0, 8191)) - 4096);
		return AXIS_W'($urandom());
	endfunction

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_wr <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_HARD_IRON_X, REG_HARD_IRON_Y, REG_HARD_IRON_Z: cal_regs[idx] = {32'h0, val[15:0]};
			REG_MIN_FIELD_SQ, REG_MAX_FIELD_SQ: cal_regs[idx] = {16'h0, val[31:0]};
			default: cal_regs[idx] = val;
		endcase
	endtask

	task automatic load_cal_regs(input reg_file_t set);
		for (int i = 0; i < 8; i++)
			write_reg(IDX_W'(i), set[i]);
		cfg_wr <= 1'b0;
	endtask

	// Always waits on the clock before it checks, so start is never driven twice in one step.
	task automatic wait_results_in();
		start <= 1'b0;
		do
			@(posedge clk);
		while (pending_cal.size() != 0);
	endtask

	task automatic send_sample(input in_t s, input bit known, input out_t want);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		sample <= s;
		do
			@(posedge clk);
		while (busy);
		pending_cal.push_back(known ? want : correct_sample(s));
	endtask

	always @(posedge clk) begin : check_results
		out_t want;
		if (arst_n && done) begin
			if (pending_cal.size() == 0) begin
				$display("%0t: unexpected transaction, got %h", $time, result);
				errors++;
			end else begin
				want = pending_cal.pop_front();
				if (result.cal_x !== want.cal_x) begin
					$display("%0t: cal_x expected %0d, got %0d", $time, want.cal_x, result.cal_x);
					errors++;
				end
				if (result.cal_y !== want.cal_y) begin
					$display("%0t: cal_y expected %0d, got %0d", $time, want.cal_y, result.cal_y);
					errors++;
				end
				if (result.cal_z !== want.cal_z) begin
					$display("%0t: cal_z expected %0d, got %0d", $time, want.cal_z, result.cal_z);
					errors++;
				end
				if (result.disturbed !== want.disturbed) begin
					$display("%0t: disturbed expected %b, got %b", $time, want.disturbed,
						result.disturbed);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == IDLE_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		int cur_cfg;
		reg_file_t nxt;
		logic [31:0] lo_sq;
		int nb;
		arst_n <= 1'b0;
		start <= 1'b0;
		sample <= '0;
		cfg_wr <= 1'b0;
		cfg_idx <= '0;
		cfg_data <= '0;
		cal_regs = dir_cfg[0];
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		cur_cfg = 0;
		foreach (dir_tab[i]) begin
			if (dir_tab[i].cfg != cur_cfg) begin
				wait_results_in();
				load_cal_regs(dir_cfg[dir_tab[i].cfg]);
				cur_cfg = dir_tab[i].cfg;
			end
			send_sample(dir_tab[i].smp, dir_tab[i].known, dir_tab[i].want);
		end

		for (int p = 0; p < NUM_PHASES; p++) begin
			rad_bits = $urandom_range(4, 14);
			steady = ($urandom_range(0, 3) == 0);
			case (p)
				0: nxt = '{48'h7FFF, 48'h7FFF, 48'h7FFF, 48'h8000_8000_8000,
					48'h8000_8000_8000, 48'h8000_8000_8000, 48'h0, 48'h0};
				1: nxt = '{48'hFFFF_FFFF_8000, 48'hFFFF_FFFF_8000, 48'hFFFF_FFFF_8000,
					48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF,
					48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF};
				2: nxt = '{48'hFFFF_FFFF_FFFF, 48'h0, 48'h0, 48'hFFFF_FFFF_FFFF,
					48'h0, 48'hFFFF_FFFF_FFFF, 48'h0, 48'hFFFF_FFFF_FFFF};
				default: begin
					for (int a = 0; a < 3; a++)
						nxt[a] = ($urandom_range(0, 1) == 0)
							? {$urandom(), 16'(int'($urandom_range(0, 4000)) - 2000)}
							: 48'({$urandom(), $urandom()});
					for (int r = 0; r < 3; r++)
						nxt[3 + r] = {rand_coef(r == 0), rand_coef(r == 1), rand_coef(r == 2)};
					// Bounds sized to the spread of the well-formed samples so that
					// both flag values show up; now and then inverted or arbitrary.
					nb = 2 * rad_bits;
					lo_sq = $urandom_range(0, 1 << (nb - 1));
					nxt[REG_MIN_FIELD_SQ] = {16'($urandom()), lo_sq};
					nxt[REG_MAX_FIELD_SQ] = {16'($urandom()),
						lo_sq + 32'($urandom_range(0, 1 << (nb + 1)))};
					if ($urandom_range(0, 9) == 0) begin
						nxt[REG_MIN_FIELD_SQ] = {16'h0, lo_sq + 32'(1 << nb)};
						nxt[REG_MAX_FIELD_SQ] = {16'h0, lo_sq};
					end else if ($urandom_range(0, 9) == 0) begin
						nxt[REG_MIN_FIELD_SQ] = 48'({$urandom(), $urandom()});
						nxt[REG_MAX_FIELD_SQ] = 48'({$urandom(), $urandom()});
					end
				end
			endcase
			wait_results_in();
			load_cal_regs(nxt);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if ($urandom_range(0, 59) == 0)
					wait_results_in();
				send_sample(rand_sample(), 0, '0);
			end
		end

		wait_results_in();
		repeat (LATENCY + 3) @(posedge clk);
		while (pending_cal.size() != 0) begin
			$display("%0t: transaction never seen, expected %h", $time, pending_cal.pop_front());
			errors++;
		end
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
